[src/mlp_pkg.sv]
// ----------------------------------------------------------------------------
// Macrocell line parser package
// Shared types and constants for the front classifier and the result queue.
// ----------------------------------------------------------------------------
package mlp_pkg;

    localparam int GRID_SIZE   = 8;
    localparam int NUMBER_BITS = 32;
    localparam int NUM_TOKENS  = 5;
    localparam int GRID_CELLS  = GRID_SIZE * GRID_SIZE;
    localparam int POS_W       = $clog2(GRID_SIZE + 1);
    localparam int TOK_W       = $clog2(NUM_TOKENS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BRACK  = 8'h5B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [2:0] KIND_DONE         = 3'd0;
    localparam logic [2:0] KIND_CELLS        = 3'd1;
    localparam logic [2:0] KIND_NODE         = 3'd2;
    localparam logic [2:0] KIND_UNRECOGNIZED = 3'd3;
    localparam logic [2:0] KIND_MALFORMED    = 3'd4;

    // One result item as it travels through the queue
    typedef struct packed {
        logic [2:0]             kind;
        logic [GRID_CELLS-1:0]  cells;
        logic [NUMBER_BITS-1:0] level;
        logic [NUMBER_BITS-1:0] nw;
        logic [NUMBER_BITS-1:0] ne;
        logic [NUMBER_BITS-1:0] sw;
        logic [NUMBER_BITS-1:0] se;
        logic                   last;
    } t_result;

    // Push request from the front: up to two results per byte
    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

endpackage

[src/mlp_front.sv]
// ----------------------------------------------------------------------------
// Macrocell line parser front
// Accepts bytes, classifies lines and builds the results of finished lines.
// ----------------------------------------------------------------------------
module mlp_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic                    i_cmd,
    input  logic [7:0]              i_char_byte,
    output mlp_pkg::t_push          o_push,
    output mlp_pkg::t_result        o_res0,
    output mlp_pkg::t_result        o_res1
);

    typedef enum logic [2:0] {
        MODE_START, MODE_SKIP, MODE_WSPEND, MODE_CELLS, MODE_NODE, MODE_BAD
    } t_mode;

    localparam logic [mlp_pkg::NUMBER_BITS-1:0] NUM_MAX = '1;
    localparam logic [mlp_pkg::NUMBER_BITS-1:0] NUM_LIM = NUM_MAX / 10;
    localparam logic [3:0] NUM_LIM_DIG = 4'(NUM_MAX % 10);

    t_mode r_mode, n_mode;
    logic [mlp_pkg::POS_W-1:0] r_col, n_col, r_row, n_row;
    logic [mlp_pkg::GRID_CELLS-1:0] r_bits, n_bits;
    logic r_ended, n_ended;
    logic [mlp_pkg::TOK_W-1:0] r_tok, n_tok;
    logic [mlp_pkg::NUMBER_BITS-1:0] r_num [mlp_pkg::NUM_TOKENS];
    logic [mlp_pkg::NUMBER_BITS-1:0] n_num [mlp_pkg::NUM_TOKENS];
    logic r_hasd, n_hasd, r_closed, n_closed, r_err, n_err, r_nonblank, n_nonblank;

    logic is_space, is_digit, finish, node_ok;
    logic [3:0] dig;
    logic [mlp_pkg::NUMBER_BITS-1:0] cur;
    t_mode mode_eff;
    mlp_pkg::t_result line_res;
    logic line_has;

    assign is_space = (i_char_byte == mlp_pkg::CH_SPACE) || (i_char_byte == mlp_pkg::CH_TAB)
                   || (i_char_byte == mlp_pkg::CH_LF) || (i_char_byte == mlp_pkg::CH_VT)
                   || (i_char_byte == mlp_pkg::CH_FF) || (i_char_byte == mlp_pkg::CH_CR);
    assign is_digit = (i_char_byte >= mlp_pkg::CH_ZERO) && (i_char_byte <= mlp_pkg::CH_NINE);
    assign dig      = 4'(i_char_byte - mlp_pkg::CH_ZERO);
    assign cur      = (r_tok < mlp_pkg::TOK_W'(mlp_pkg::NUM_TOKENS))
                    ? r_num[r_tok[mlp_pkg::TOK_W-1:0]] : '0;

    // Build the result of the pending line
    assign node_ok = !r_err && ((r_tok >= mlp_pkg::TOK_W'(mlp_pkg::NUM_TOKENS)) ||
                     (r_tok == mlp_pkg::TOK_W'(mlp_pkg::NUM_TOKENS - 1) && r_hasd));
    always_comb begin
        line_res = '0;
        line_has = 1'b0;
        case (r_mode)
            MODE_CELLS: begin
                line_has = 1'b1;
                line_res.kind = mlp_pkg::KIND_CELLS;
                line_res.cells = r_bits;
            end
            MODE_NODE: begin
                line_has = 1'b1;
                if (node_ok) begin
                    line_res.kind = mlp_pkg::KIND_NODE;
                    line_res.level = r_num[0];
                    line_res.nw = r_num[1];
                    line_res.ne = r_num[2];
                    line_res.sw = r_num[3];
                    line_res.se = r_num[4];
                end else begin
                    line_res.kind = mlp_pkg::KIND_MALFORMED;
                end
            end
            MODE_BAD: begin
                line_has = 1'b1;
                line_res.kind = mlp_pkg::KIND_UNRECOGNIZED;
            end
            default: line_has = 1'b0;
        endcase
    end

    // Next-state logic for one accepted byte
    always_comb begin
        n_mode = r_mode; n_col = r_col; n_row = r_row; n_bits = r_bits;
        n_ended = r_ended; n_tok = r_tok; n_hasd = r_hasd; n_closed = r_closed;
        n_err = r_err; n_nonblank = r_nonblank;
        for (int i = 0; i < mlp_pkg::NUM_TOKENS; i++) n_num[i] = r_num[i];
        finish = 1'b0;
        mode_eff = r_mode;
        o_push = '0;
        o_res0 = line_res;
        o_res1 = '0;
        o_res1.kind = mlp_pkg::KIND_DONE;
        o_res1.last = 1'b1;
        if (i_cmd == mlp_pkg::CMD_END) begin
            finish = 1'b1;
            if (r_nonblank && line_has) begin
                o_push.push0 = 1'b1;
                o_push.push1 = 1'b1;
            end else begin
                o_push.push0 = 1'b1;
                o_res0 = o_res1;
            end
        end else if (i_char_byte == mlp_pkg::CH_LF) begin
            finish = 1'b1;
            o_push.push0 = line_has;
            o_res0.last = 1'b1;
        end else begin
            if (r_mode == MODE_START) begin
                n_nonblank = 1'b1;
                if (i_char_byte == mlp_pkg::CH_HASH || i_char_byte == mlp_pkg::CH_BRACK)
                    mode_eff = MODE_SKIP;
                else if (i_char_byte == mlp_pkg::CH_DOLLAR || i_char_byte == mlp_pkg::CH_DOT
                         || i_char_byte == mlp_pkg::CH_STAR)
                    mode_eff = MODE_CELLS;
                else if (is_digit)
                    mode_eff = MODE_NODE;
                else if (is_space)
                    mode_eff = MODE_WSPEND;
                else
                    mode_eff = MODE_BAD;
                n_mode = mode_eff;
            end else if (r_mode == MODE_WSPEND) begin
                if (!is_space) n_mode = MODE_BAD;
                mode_eff = MODE_SKIP;
            end
            // Cell run decode
            if (mode_eff == MODE_CELLS && !r_ended) begin
                if (i_char_byte == mlp_pkg::CH_DOT) begin
                    if (r_col < mlp_pkg::POS_W'(mlp_pkg::GRID_SIZE)) n_col = r_col + 1'b1;
                end else if (i_char_byte == mlp_pkg::CH_STAR) begin
                    if (r_col < mlp_pkg::POS_W'(mlp_pkg::GRID_SIZE)) begin
                        n_col = r_col + 1'b1;
                        if (r_row < mlp_pkg::POS_W'(mlp_pkg::GRID_SIZE))
                            n_bits[$clog2(mlp_pkg::GRID_CELLS)'(r_row) *
                                   $clog2(mlp_pkg::GRID_CELLS)'(mlp_pkg::GRID_SIZE) +
                                   $clog2(mlp_pkg::GRID_CELLS)'(r_col)] = 1'b1;
                    end
                end else if (i_char_byte == mlp_pkg::CH_DOLLAR) begin
                    if (r_row < mlp_pkg::POS_W'(mlp_pkg::GRID_SIZE)) n_row = r_row + 1'b1;
                    n_col = '0;
                end else begin
                    n_ended = 1'b1;
                end
            end
            // Node token decode
            if (mode_eff == MODE_NODE) begin
                if (i_char_byte == mlp_pkg::CH_SPACE) begin
                    if (r_tok < mlp_pkg::TOK_W'(mlp_pkg::NUM_TOKENS)) begin
                        if (!r_hasd) n_err = 1'b1;
                        n_tok = r_tok + 1'b1;
                    end
                    n_hasd = 1'b0;
                    n_closed = 1'b0;
                end else if (r_tok < mlp_pkg::TOK_W'(mlp_pkg::NUM_TOKENS)) begin
                    if (is_digit) begin
                        if (r_closed || cur > NUM_LIM || (cur == NUM_LIM && dig > NUM_LIM_DIG))
                            n_err = 1'b1;
                        else
                            n_num[r_tok[mlp_pkg::TOK_W-1:0]] =
                                mlp_pkg::NUMBER_BITS'(cur * 10) +
                                mlp_pkg::NUMBER_BITS'(dig);
                        n_hasd = 1'b1;
                    end else if (is_space) begin
                        if (r_hasd) n_closed = 1'b1;
                    end else begin
                        n_err = 1'b1;
                    end
                end
            end
        end
        // Return to start of line
        if (finish) begin
            n_mode = MODE_START; n_col = '0; n_row = '0; n_bits = '0; n_ended = 1'b0;
            n_tok = '0; n_hasd = 1'b0; n_closed = 1'b0; n_err = 1'b0; n_nonblank = 1'b0;
            for (int i = 0; i < mlp_pkg::NUM_TOKENS; i++) n_num[i] = '0;
        end
        if (!i_fire) o_push = '0;
    end

    // Hold line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START; r_col <= '0; r_row <= '0; r_bits <= '0; r_ended <= 1'b0;
            r_tok <= '0; r_hasd <= 1'b0; r_closed <= 1'b0; r_err <= 1'b0;
            r_nonblank <= 1'b0;
            for (int i = 0; i < mlp_pkg::NUM_TOKENS; i++) r_num[i] <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode; r_col <= n_col; r_row <= n_row; r_bits <= n_bits;
            r_ended <= n_ended; r_tok <= n_tok; r_hasd <= n_hasd; r_closed <= n_closed;
            r_err <= n_err; r_nonblank <= n_nonblank;
            for (int i = 0; i < mlp_pkg::NUM_TOKENS; i++) r_num[i] <= n_num[i];
        end
    end

endmodule

[src/mlp_queue.sv]
// ----------------------------------------------------------------------------
// Macrocell line parser result queue
// Takes up to two results a cycle and delivers one a cycle downstream while i_ready is high.
// ----------------------------------------------------------------------------
module mlp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mlp_pkg::t_push     i_push,
    input  mlp_pkg::t_result   i_res0,
    input  mlp_pkg::t_result   i_res1,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output mlp_pkg::t_result   o_res
);

    mlp_pkg::t_result r_mem [mlp_pkg::QUEUE_DEPTH];
    logic [mlp_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [mlp_pkg::QPTR_W:0]   r_cnt, n_cnt;
    logic pop;
    logic [mlp_pkg::QPTR_W-1:0] wr1;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    // Room only while two results fit, so an accepted byte never overflows the queue
    assign o_room  = (r_cnt <= (mlp_pkg::QPTR_W+1)'(mlp_pkg::QUEUE_DEPTH - 2));
    assign wr1     = r_wr + 1'b1;
    assign n_cnt   = r_cnt + (mlp_pkg::QPTR_W+1)'(i_push.push0)
                   + (mlp_pkg::QPTR_W+1)'(i_push.push1) - (mlp_pkg::QPTR_W+1)'(pop);

    // Write entries
    always_ff @(posedge i_clk) begin
        if (i_push.push0) r_mem[r_wr] <= i_res0;
        if (i_push.push1) r_mem[wr1] <= i_res1;
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + mlp_pkg::QPTR_W'(i_push.push0) + mlp_pkg::QPTR_W'(i_push.push1);
            r_rd  <= r_rd + mlp_pkg::QPTR_W'(pop);
            r_cnt <= n_cnt;
        end
    end

endmodule

[src/macrocell_line_parser_top.sv]
// A result is written into the queue on the byte that ends its line.
// One byte per cycle while the queue has room for two results; results leave
// at one per cycle through a four-entry queue while the downstream is ready.
// Reset: synchronous, active low; the parser goes to start of line and the
// queue empties.
// ----------------------------------------------------------------------------
// Macrocell line parser top level
// Front classifier feeding a small result queue.
// ----------------------------------------------------------------------------
module macrocell_line_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_char_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_line_kind,
    output logic [63:0] o_cell_bits,
    output logic [31:0] o_node_level,
    output logic [31:0] o_north_west,
    output logic [31:0] o_north_east,
    output logic [31:0] o_south_west,
    output logic [31:0] o_south_east,
    output logic        o_last_of_run
);

    mlp_pkg::t_push   push;
    mlp_pkg::t_result res0, res1, q_res;
    logic room;

    assign o_ready = room;

    mlp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fire(i_valid && room),
        .i_cmd(i_cmd), .i_char_byte(i_char_byte),
        .o_push(push), .o_res0(res0), .o_res1(res1)
    );

    mlp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_res0(res0), .i_res1(res1),
        .o_room(room), .o_valid(o_valid), .i_ready(i_ready), .o_res(q_res)
    );

    // Drive result fields
    assign o_line_kind   = q_res.kind;
    assign o_cell_bits   = q_res.cells;
    assign o_node_level  = q_res.level;
    assign o_north_west  = q_res.nw;
    assign o_north_east  = q_res.ne;
    assign o_south_west  = q_res.sw;
    assign o_south_east  = q_res.se;
    assign o_last_of_run = q_res.last;

endmodule

[src/mlp_checker.sv]
// ----------------------------------------------------------------------------
// Macrocell line parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module mlp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_cmd,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_line_kind,
    input logic [63:0] o_cell_bits,
    input logic        o_last_of_run
);

    // Results come out held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_line_kind))
        else $error("result changed while stalled");

    // Done result always closes a run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_kind == mlp_pkg::KIND_DONE |-> o_last_of_run)
        else $error("done result without last flag");

    // Kind stays within the defined codes
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_line_kind <= mlp_pkg::KIND_MALFORMED)
        else $error("bad result kind");

    // Only bitmap results carry cells
    a_cells_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_kind != mlp_pkg::KIND_CELLS |-> o_cell_bits == '0)
        else $error("cells on non-bitmap result");

    // An accepted end of input makes a result available next cycle
    a_end_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_cmd |=> o_valid)
        else $error("no result after end of input");

endmodule

bind macrocell_line_parser_top mlp_checker u_mlp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_cmd(i_cmd), .o_valid(o_valid), .i_ready(i_ready), .o_line_kind(o_line_kind),
    .o_cell_bits(o_cell_bits), .o_last_of_run(o_last_of_run)
);

[tb/sv/macrocell_line_parser_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Macrocell line parser checker
// Watches the byte and result channels, predicts the results of each accepted
// request with its own line parser, and compares them field by field.
// ----------------------------------------------------------------------------
module macrocell_line_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic        i_cmd,
    input  logic [7:0]  i_char_byte,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [2:0]  i_line_kind,
    input  logic [63:0] i_cell_bits,
    input  logic [31:0] i_node_level,
    input  logic [31:0] i_north_west,
    input  logic [31:0] i_north_east,
    input  logic [31:0] i_south_west,
    input  logic [31:0] i_south_east,
    input  logic        i_last_of_run,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);

    typedef enum logic [2:0] {
        LM_START, LM_SKIP, LM_WSPEND, LM_CELLS, LM_NODE, LM_BAD
    } t_line_mode;

    t_line_mode  mode;
    logic [3:0]  col, row;
    logic [63:0] bitmap;
    logic        run_done;
    logic [2:0]  tok_idx;
    logic [63:0] nums [mlp_pkg::NUM_TOKENS];
    logic        has_digit, tok_closed, line_err, nonblank;

    mlp_pkg::t_result expected_results [$];

    function automatic logic is_ws(logic [7:0] c);
        return c == mlp_pkg::CH_SPACE || c == mlp_pkg::CH_TAB || c == mlp_pkg::CH_LF ||
               c == mlp_pkg::CH_VT || c == mlp_pkg::CH_FF || c == mlp_pkg::CH_CR;
    endfunction

    function automatic logic is_dig(logic [7:0] c);
        return c >= mlp_pkg::CH_ZERO && c <= mlp_pkg::CH_NINE;
    endfunction

    function automatic void clear_line();
        mode = LM_START; col = 0; row = 0; bitmap = '0; run_done = 0;
        tok_idx = 0; has_digit = 0; tok_closed = 0; line_err = 0; nonblank = 0;
        for (int i = 0; i < mlp_pkg::NUM_TOKENS; i++) nums[i] = '0;
    endfunction

    function automatic void push_result(logic [2:0] kind, logic [63:0] bits,
                                        logic with_nums);
        mlp_pkg::t_result r;
        r = '0;
        r.kind = kind;
        r.cells = bits;
        if (with_nums) begin
            r.level = nums[0][31:0]; r.nw = nums[1][31:0]; r.ne = nums[2][31:0];
            r.sw = nums[3][31:0]; r.se = nums[4][31:0];
        end
        expected_results.push_back(r);
    endfunction

    // Close the current line; return 1 when it gave a result
    function automatic logic finish_line();
        logic gave;
        gave = 1;
        case (mode)
            LM_CELLS: push_result(mlp_pkg::KIND_CELLS, bitmap, 1'b0);
            LM_NODE: begin
                if (!line_err && (tok_idx >= mlp_pkg::NUM_TOKENS ||
                        (tok_idx == mlp_pkg::NUM_TOKENS - 1 && has_digit)))
                    push_result(mlp_pkg::KIND_NODE, '0, 1'b1);
                else
                    push_result(mlp_pkg::KIND_MALFORMED, '0, 1'b0);
            end
            LM_BAD: push_result(mlp_pkg::KIND_UNRECOGNIZED, '0, 1'b0);
            default: gave = 0;
        endcase
        clear_line();
        return gave;
    endfunction

    task automatic cell_char(logic [7:0] c);
        if (run_done) return;
        if (c == mlp_pkg::CH_DOT) begin
            if (col < mlp_pkg::GRID_SIZE) col++;
        end else if (c == mlp_pkg::CH_STAR) begin
            if (col < mlp_pkg::GRID_SIZE && row < mlp_pkg::GRID_SIZE)
                bitmap[row * mlp_pkg::GRID_SIZE + col] = 1'b1;
            if (col < mlp_pkg::GRID_SIZE) col++;
        end else if (c == mlp_pkg::CH_DOLLAR) begin
            if (row < mlp_pkg::GRID_SIZE) row++;
            col = 0;
        end else begin
            run_done = 1;
        end
    endtask

    task automatic node_char(logic [7:0] c);
        logic [63:0] d, v, lim;
        lim = (64'd1 << mlp_pkg::NUMBER_BITS) - 1;
        if (c == mlp_pkg::CH_SPACE) begin
            if (tok_idx < mlp_pkg::NUM_TOKENS) begin
                if (!has_digit) line_err = 1;
                tok_idx++;
            end
            has_digit = 0; tok_closed = 0;
            return;
        end
        if (tok_idx >= mlp_pkg::NUM_TOKENS) return;
        if (is_dig(c)) begin
            d = 64'(c - mlp_pkg::CH_ZERO);
            v = nums[tok_idx];
            if (tok_closed || v > (lim - d) / 10) line_err = 1;
            else nums[tok_idx] = v * 10 + d;
            has_digit = 1;
        end else if (is_ws(c)) begin
            if (has_digit) tok_closed = 1;
        end else begin
            line_err = 1;
        end
    endtask

    // Advance the prediction by one accepted request
    task automatic predict_request(logic cmd, logic [7:0] c);
        int first;
        first = expected_results.size();
        if (cmd == mlp_pkg::CMD_END) begin
            if (nonblank) void'(finish_line());
            clear_line();
            push_result(mlp_pkg::KIND_DONE, '0, 1'b0);
        end else if (c == mlp_pkg::CH_LF) begin
            void'(finish_line());
        end else begin
            if (mode == LM_START) begin
                nonblank = 1;
                if (c == mlp_pkg::CH_HASH || c == mlp_pkg::CH_BRACK) mode = LM_SKIP;
                else if (c == mlp_pkg::CH_DOLLAR || c == mlp_pkg::CH_DOT ||
                         c == mlp_pkg::CH_STAR) mode = LM_CELLS;
                else if (is_dig(c)) mode = LM_NODE;
                else if (is_ws(c)) mode = LM_WSPEND;
                else mode = LM_BAD;
            end else if (mode == LM_WSPEND) begin
                if (!is_ws(c)) mode = LM_BAD;
                return;
            end
            if (mode == LM_CELLS) cell_char(c);
            else if (mode == LM_NODE) node_char(c);
        end
        if (expected_results.size() > first)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    task automatic compare_result();
        mlp_pkg::t_result e;
        if (expected_results.size() == 0) begin
            $error("result with no expectation waiting: kind %0d", i_line_kind);
            o_fail_count++;
            return;
        end
        e = expected_results.pop_front();
        if (i_line_kind !== e.kind) begin
            $error("line_kind expected %0d actual %0d", e.kind, i_line_kind); o_fail_count++;
        end
        if (i_cell_bits !== e.cells) begin
            $error("cell_bits expected %h actual %h", e.cells, i_cell_bits); o_fail_count++;
        end
        if (i_node_level !== e.level) begin
            $error("node_level expected %0d actual %0d", e.level, i_node_level); o_fail_count++;
        end
        if (i_north_west !== e.nw) begin
            $error("north_west expected %0d actual %0d", e.nw, i_north_west); o_fail_count++;
        end
        if (i_north_east !== e.ne) begin
            $error("north_east expected %0d actual %0d", e.ne, i_north_east); o_fail_count++;
        end
        if (i_south_west !== e.sw) begin
            $error("south_west expected %0d actual %0d", e.sw, i_south_west); o_fail_count++;
        end
        if (i_south_east !== e.se) begin
            $error("south_east expected %0d actual %0d", e.se, i_south_east); o_fail_count++;
        end
        if (i_last_of_run !== e.last) begin
            $error("last_of_run expected %0d actual %0d", e.last, i_last_of_run);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
        o_pending = 0;
        clear_line();
    end

    // Sample both channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
        end else begin
            if (i_res_valid && i_res_ready) begin
                compare_result();
                o_result_count++;
            end
            if (i_valid && i_ready_in) predict_request(i_cmd, i_char_byte);
        end
        o_pending = expected_results.size();
    end

endmodule

[tb/sv/macrocell_line_parser_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Macrocell line parser test
// Feeds directed and random text streams in bursts against a stalling result
// side; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module macrocell_line_parser_top_test;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic        cmd = mlp_pkg::CMD_BYTE;
    logic [7:0]  char_byte = '0;
    logic        res_valid;
    logic        res_ready = 0;
    logic [2:0]  line_kind;
    logic [63:0] cell_bits;
    logic [31:0] node_level, north_west, north_east, south_west, south_east;
    logic        last_of_run;
    int          fail_count, pending, result_count;
    int          requests_sent;
    logic        sender_done = 0;

    typedef logic [7:0] t_text [$];

    always begin
        #6 clk = 1;
        #6 clk = 0;
    end

    macrocell_line_parser_top uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_cmd(cmd), .i_char_byte(char_byte), .o_valid(res_valid), .i_ready(res_ready),
        .o_line_kind(line_kind), .o_cell_bits(cell_bits), .o_node_level(node_level),
        .o_north_west(north_west), .o_north_east(north_east),
        .o_south_west(south_west), .o_south_east(south_east),
        .o_last_of_run(last_of_run)
    );

    macrocell_line_parser_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_ready_in(in_ready),
        .i_cmd(cmd), .i_char_byte(char_byte), .i_res_valid(res_valid),
        .i_res_ready(res_ready), .i_line_kind(line_kind), .i_cell_bits(cell_bits),
        .i_node_level(node_level), .i_north_west(north_west),
        .i_north_east(north_east), .i_south_west(south_west),
        .i_south_east(south_east), .i_last_of_run(last_of_run),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // Stall the result side in phases: free flow, light and heavy stalls
    always @(posedge clk) begin
        int phase;
        phase = (requests_sent / 200) % 3;
        if (sender_done || phase == 0) res_ready <= 1'b1;
        else if (phase == 1) res_ready <= ($urandom_range(0, 3) != 0);
        else res_ready <= ($urandom_range(0, 2) == 0);
    end

    int burst_left = 0;

    // Send one request; gaps come between bursts of random length
    task automatic send_request(logic c, logic [7:0] b);
        while (burst_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                burst_left = $urandom_range(1, 30);
            end else begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= c;
        char_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_text(t_text t);
        foreach (t[i]) send_request(mlp_pkg::CMD_BYTE, t[i]);
    endtask

    function automatic t_text str_bytes(string s);
        t_text t;
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        return t;
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 4))
            0: return mlp_pkg::CH_SPACE;
            1: return mlp_pkg::CH_TAB;
            2: return mlp_pkg::CH_VT;
            3: return mlp_pkg::CH_FF;
            default: return mlp_pkg::CH_CR;
        endcase
    endfunction

    // Build a random line of cell run characters
    function automatic t_text cell_line();
        t_text t;
        int n;
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: t.push_back(mlp_pkg::CH_DOT);
                3, 4, 5, 6: t.push_back(mlp_pkg::CH_STAR);
                7, 8: t.push_back(mlp_pkg::CH_DOLLAR);
                default: t.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        if (t[0] != mlp_pkg::CH_DOT && t[0] != mlp_pkg::CH_STAR &&
            t[0] != mlp_pkg::CH_DOLLAR) t[0] = mlp_pkg::CH_STAR;
        return t;
    endfunction

    // Build a node line, mostly well formed, sometimes broken
    function automatic t_text node_line();
        t_text t;
        int ntok;
        logic [31:0] v;
        ntok = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 5;
        for (int k = 0; k < ntok; k++) begin
            if (k > 0) t.push_back(mlp_pkg::CH_SPACE);
            case ($urandom_range(0, 9))
                0: v = 32'hFFFF_FFFF;
                1: v = $urandom_range(0, 9);
                default: v = $urandom;
            endcase
            if ($urandom_range(0, 12) == 0 && k > 0) begin
                if ($urandom_range(0, 1)) t.push_back(8'($urandom_range(0, 255)));
                continue;
            end
            if ($urandom_range(0, 15) == 0) t.push_back(pick_ws());
            t = {t, str_bytes($sformatf("%0d", v))};
            if ($urandom_range(0, 20) == 0)
                t.push_back(8'(mlp_pkg::CH_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 15) == 0) t.push_back(pick_ws());
        end
        if (t.size() == 0 || !(t[0] >= mlp_pkg::CH_ZERO && t[0] <= mlp_pkg::CH_NINE))
            t.push_front(8'(mlp_pkg::CH_ZERO + $urandom_range(0, 9)));
        return t;
    endfunction

    task automatic send_random_line();
        t_text t;
        case ($urandom_range(0, 9))
            0, 1, 2: t = cell_line();
            3, 4, 5, 6: t = node_line();
            7: begin
                t.push_back($urandom_range(0, 1) ? mlp_pkg::CH_HASH : mlp_pkg::CH_BRACK);
                repeat ($urandom_range(0, 5)) t.push_back(8'($urandom_range(0, 255)));
            end
            8: repeat ($urandom_range(0, 3)) t.push_back(pick_ws());
            default: repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
        endcase
        send_text(t);
        if ($urandom_range(0, 15) == 0)
            send_request(mlp_pkg::CMD_END, 8'($urandom_range(0, 255)));
        else
            send_request(mlp_pkg::CMD_BYTE, mlp_pkg::CH_LF);
    endtask

    initial begin
        requests_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one line of each kind and the edge cases
        send_text(str_bytes("*.*$.*\n"));
        send_text(str_bytes("4294967295 0 1 2 3\n"));
        send_text(str_bytes("4294967296 0 1 2 3\n1 2 3\n"));
        send_text(str_bytes("1  2 3 4 5\n1 2 -3 4 5 6 7\n"));
        send_text(str_bytes("# comment\n[x\n \t\n z\nqq\n\n"));
        send_text(str_bytes("*********$$$$$$$$$*\n"));
        send_text(str_bytes("1 2 3 4 5 x\n9\t 2 3 4 5\n"));
        send_request(mlp_pkg::CMD_BYTE, 8'hFF);
        send_request(mlp_pkg::CMD_END, 8'h00);
        send_request(mlp_pkg::CMD_END, 8'hFF);

        // Random lines
        while (requests_sent < 1600) send_random_line();
        send_request(mlp_pkg::CMD_END, 8'h00);
        in_valid <= 1'b0;
        sender_done <= 1'b1;

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d byte and end-of-input requests; checked %0d results.",
                 requests_sent, result_count);
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    // Hold a hard limit in case a handshake hangs
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
